// ----- design/ghrt_pkg.sv -----
// Shared constants for the generational handle refcount table.
// Status, action and register codes, default sizes and port widths.
// No dependencies.
`timescale 1ns / 1ps

package ghrt_pkg;

    // Default build sizes
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int COUNT_BITS_DEF  = 16;

    // Field widths fixed by the interface
    localparam int ACTION_W   = 2;
    localparam int INDEX_W    = 10;
    localparam int SID_W      = 32;
    localparam int STATUS_W   = 3;
    localparam int REFOUT_W   = 16;
    localparam int LIMIT_W    = 11;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 64;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    // Actions
    localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ACQUIRE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NONE    = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLOSING  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_LIMIT    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_STALE    = 3'd6;
    localparam logic [STATUS_W-1:0] ST_NOREF    = 3'd7;

    // Register index, taken from paddr[2]
    localparam logic REG_SLOT_LIMIT = 1'b0;

endpackage

// ----- design/generational_handle_refcount_table.sv -----
// Top level of the generational handle refcount table.
// Depends on ghrt_pkg and ghrt_ram (slot table and free stack).
//
// Channel   | Dir | Handshake                 | Word contents (low bit up)
// ----------+-----+---------------------------+-----------------------------------------
// s_axis    | in  | tvalid/tready             | action[1:0] slot_index[11:2]
//           |     |                           | session_id[43:12], zero pad to 48
// m_axis    | out | tvalid/tready             | status[2:0] result_index[12:3]
//           |     |                           | result_id[44:13] ref_count[60:45], pad
// apb       | in  | psel/penable/pwrite/pready| slot_limit at byte address 0
//
// Flow: one word at a time. The accept edge reads the slot entry and the top of the
// free stack; in the execute state the word is evaluated, written back and the
// output register is loaded. No new word is taken until that read-modify-write is done.
// An action code 3 word is taken and produces nothing.
// Stalls: an evaluated word waits in the execute state while the output register
// still holds an untaken result. Reset: synchronous, no clearing pass; slot
// entries at or above the fresh-index count read as zero.
`timescale 1ns / 1ps

module generational_handle_refcount_table #(
    parameter int TABLE_DEPTH = ghrt_pkg::TABLE_DEPTH_DEF,
    parameter int COUNT_BITS  = ghrt_pkg::COUNT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // stream in
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // action[1:0], slot_index[11:2], session_id[43:12], zeros[47:44]
    input  logic [ghrt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // stream out
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // status[2:0], result_index[12:3], result_id[44:13], ref_count[60:45], zeros[63:61]
    output logic [ghrt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // config
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ghrt_pkg::PADDR_W-1:0]      paddr,
    input  logic [ghrt_pkg::PDATA_W-1:0]      pwdata,
    output logic [ghrt_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    localparam int AW      = $clog2(TABLE_DEPTH);       // slot address
    localparam int CW      = $clog2(TABLE_DEPTH + 1);   // counts up to depth
    localparam int ENT_W   = 2 + COUNT_BITS + ghrt_pkg::SID_W;
    // entry layout: {closing, live, refs, generation}
    localparam int GEN_LO  = 0;
    localparam int REF_LO  = ghrt_pkg::SID_W;
    localparam int LIVE_B  = ghrt_pkg::SID_W + COUNT_BITS;
    localparam int CLOS_B  = LIVE_B + 1;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;

    // captured word
    logic [ghrt_pkg::ACTION_W-1:0] r_action;
    logic [ghrt_pkg::INDEX_W-1:0]  r_idx;
    logic [ghrt_pkg::SID_W-1:0]    r_sid;

    // table bookkeeping
    logic [CW-1:0]                 r_free_depth, n_free_depth;
    logic [CW-1:0]                 r_fresh,      n_fresh;
    logic [ghrt_pkg::SID_W-1:0]    r_id_ctr,     n_id_ctr;
    logic [ghrt_pkg::LIMIT_W-1:0]  r_limit;

    // output register
    logic                          r_m_valid;
    logic [ghrt_pkg::OUT_DATA_W-1:0] r_m_data;

    // ---------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------
    logic w_in_acc;
    logic w_can_emit;
    logic w_commit;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_can_emit    = !r_m_valid || m_axis_tready;
    assign w_commit      = (r_state == S_EXEC) && w_can_emit;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // incoming fields
    logic [ghrt_pkg::ACTION_W-1:0] w_in_action;
    logic [ghrt_pkg::INDEX_W-1:0]  w_in_idx;
    logic [ghrt_pkg::SID_W-1:0]    w_in_sid;
    logic [31:0]                   w_in_idx32;

    assign w_in_action = s_axis_tdata[1:0];
    assign w_in_idx    = s_axis_tdata[11:2];
    assign w_in_sid    = s_axis_tdata[43:12];
    assign w_in_idx32  = 32'(w_in_idx);

    // ---------------------------------------------------------------
    // Config port
    // ---------------------------------------------------------------
    logic w_cfg_we;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready
                      && (paddr[2] == ghrt_pkg::REG_SLOT_LIMIT);
    assign prdata   = (paddr[2] == ghrt_pkg::REG_SLOT_LIMIT)
                      ? ghrt_pkg::PDATA_W'(r_limit) : '0;

    // effective limit = min(slot_limit, depth)
    logic [31:0] w_eff32;
    assign w_eff32 = (32'(r_limit) < 32'(TABLE_DEPTH)) ? 32'(r_limit) : 32'(TABLE_DEPTH);

    // ---------------------------------------------------------------
    // Memories
    // ---------------------------------------------------------------
    logic             w_slot_we;
    logic [AW-1:0]    w_slot_waddr;
    logic [ENT_W-1:0] w_slot_wdata;
    logic [ENT_W-1:0] w_slot_rdata;

    logic             w_stk_we;
    logic [AW-1:0]    w_stk_waddr;
    logic [AW-1:0]    w_stk_raddr;
    logic [AW-1:0]    w_stk_rdata;
    logic [CW-1:0]    w_depth_m1;

    assign w_depth_m1  = r_free_depth - CW'(1);
    assign w_stk_raddr = w_depth_m1[AW-1:0];
    assign w_stk_waddr = r_free_depth[AW-1:0];

    ghrt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_slot_we),
        .i_waddr (w_slot_waddr),
        .i_wdata (w_slot_wdata),
        .i_re    (w_in_acc),
        .i_raddr (w_in_idx32[AW-1:0]),
        .o_rdata (w_slot_rdata)
    );

    ghrt_ram #(
        .WIDTH (AW),
        .DEPTH (TABLE_DEPTH)
    ) u_free_stack (
        .i_clk   (i_clk),
        .i_we    (w_stk_we),
        .i_waddr (w_stk_waddr),
        .i_wdata (w_slot_waddr),
        .i_re    (w_in_acc),
        .i_raddr (w_stk_raddr),
        .o_rdata (w_stk_rdata)
    );

    // ---------------------------------------------------------------
    // Slot entry view: entries never handed out (index >= fresh count)
    // read as all zero.
    // ---------------------------------------------------------------
    logic [31:0]                  w_idx32;
    logic                         w_ent_ok;
    logic [ghrt_pkg::SID_W-1:0]   w_gen;
    logic [COUNT_BITS-1:0]        w_refs;
    logic                         w_live;
    logic                         w_closing;

    assign w_idx32   = 32'(r_idx);
    assign w_ent_ok  = w_idx32 < 32'(r_fresh);
    assign w_gen     = w_ent_ok ? w_slot_rdata[GEN_LO +: ghrt_pkg::SID_W] : '0;
    assign w_refs    = w_ent_ok ? w_slot_rdata[REF_LO +: COUNT_BITS] : '0;
    assign w_live    = w_ent_ok && w_slot_rdata[LIVE_B];
    assign w_closing = w_ent_ok && w_slot_rdata[CLOS_B];

    // ---------------------------------------------------------------
    // Evaluate
    // ---------------------------------------------------------------
    logic [ghrt_pkg::STATUS_W-1:0] w_status;
    logic [31:0]                   w_out_idx32;
    logic [ghrt_pkg::SID_W-1:0]    w_out_id;
    logic [COUNT_BITS-1:0]         w_out_ref;
    logic [31:0]                   w_out_ref32;
    logic [AW-1:0]                 w_alloc_slot;
    logic                          w_wr_slot;
    logic                          w_push;
    logic [COUNT_BITS-1:0]         w_ref_dec;
    logic [COUNT_BITS-1:0]         w_ref_inc;

    assign w_ref_dec = w_refs - COUNT_BITS'(1);
    assign w_ref_inc = w_refs + COUNT_BITS'(1);

    always_comb begin
        w_status     = ghrt_pkg::ST_OK;
        w_out_idx32  = w_idx32;
        w_out_id     = w_gen;
        w_out_ref    = w_refs;
        w_alloc_slot = r_fresh[AW-1:0];
        w_wr_slot    = 1'b0;
        w_push       = 1'b0;
        w_slot_waddr = w_idx32[AW-1:0];
        w_slot_wdata = {w_closing, w_live, w_refs, w_gen};
        n_free_depth = r_free_depth;
        n_fresh      = r_fresh;
        n_id_ctr     = r_id_ctr;

        unique case (r_action) inside
            ghrt_pkg::ACT_ALLOC: begin
                n_id_ctr = r_id_ctr + 32'd1;
                if (r_free_depth != '0) begin
                    w_alloc_slot = w_stk_rdata;
                    n_free_depth = w_depth_m1;
                    w_wr_slot    = 1'b1;
                end else if (32'(r_fresh) < w_eff32) begin
                    n_fresh   = r_fresh + CW'(1);
                    w_wr_slot = 1'b1;
                end else begin
                    w_status = ghrt_pkg::ST_FULL;
                    n_id_ctr = r_id_ctr;
                end
                w_slot_waddr = w_alloc_slot;
                w_slot_wdata = {1'b0, 1'b1, {COUNT_BITS{1'b0}}, n_id_ctr};
                w_out_idx32  = w_wr_slot ? 32'(w_alloc_slot) : 32'd0;
                w_out_id     = w_wr_slot ? n_id_ctr : '0;
                w_out_ref    = '0;
            end
            ghrt_pkg::ACT_ACQUIRE, ghrt_pkg::ACT_RELEASE: begin
                if (w_idx32 >= w_eff32) begin
                    w_status  = ghrt_pkg::ST_RANGE;
                    w_out_id  = '0;
                    w_out_ref = '0;
                end else if (w_closing) begin
                    w_status = ghrt_pkg::ST_CLOSING;
                end else if (r_action == ghrt_pkg::ACT_ACQUIRE) begin
                    if (!w_live) begin
                        w_status = ghrt_pkg::ST_STALE;
                    end else if (w_refs == {COUNT_BITS{1'b1}}) begin
                        w_status = ghrt_pkg::ST_LIMIT;
                    end else if (w_gen != r_sid) begin
                        w_status = ghrt_pkg::ST_STALE;
                    end else begin
                        w_out_ref    = w_ref_inc;
                        w_wr_slot    = 1'b1;
                        w_slot_wdata = {1'b0, 1'b1, w_ref_inc, w_gen};
                    end
                end else begin
                    if (w_refs == '0) begin
                        w_status = ghrt_pkg::ST_NOREF;
                    end else if (w_ref_dec == '0) begin
                        // last reference: mark closing and recycle the slot
                        w_status     = ghrt_pkg::ST_RELEASED;
                        w_out_ref    = '0;
                        w_wr_slot    = 1'b1;
                        w_slot_wdata = {1'b1, 1'b0, w_ref_dec, w_gen};
                        if (32'(r_free_depth) < 32'(TABLE_DEPTH)) begin
                            w_push       = 1'b1;
                            n_free_depth = r_free_depth + CW'(1);
                        end
                    end else begin
                        w_out_ref    = w_ref_dec;
                        w_wr_slot    = 1'b1;
                        w_slot_wdata = {w_closing, w_live, w_ref_dec, w_gen};
                    end
                end
            end
            default: begin
                w_status = ghrt_pkg::ST_OK;
            end
        endcase
    end

    assign w_slot_we   = w_commit && w_wr_slot;
    assign w_stk_we    = w_commit && w_push;
    assign w_out_ref32 = 32'(w_out_ref);

    // ---------------------------------------------------------------
    // State, bookkeeping and output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_free_depth <= '0;
            r_fresh      <= '0;
            r_id_ctr     <= '0;
            r_limit      <= ghrt_pkg::LIMIT_W'(1024);
            r_m_valid    <= 1'b0;
        end else begin
            if (w_cfg_we) begin
                r_limit <= pwdata[ghrt_pkg::LIMIT_W-1:0];
            end

            // a new result replaces the one taken at this edge
            if (w_commit) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_action <= w_in_action;
                        r_idx    <= w_in_idx;
                        r_sid    <= w_in_sid;
                        if (w_in_action != ghrt_pkg::ACT_NONE) begin
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_EXEC: begin
                    if (w_can_emit) begin
                        r_free_depth <= n_free_depth;
                        r_fresh      <= n_fresh;
                        r_id_ctr     <= n_id_ctr;
                        r_m_data     <= {3'b000, w_out_ref32[15:0], w_out_id,
                                         w_out_idx32[9:0], w_status};
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- design/ghrt_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// Used for the slot table and the free stack. No dependencies.
`timescale 1ns / 1ps

module ghrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/ghrt_chk.sv -----
// Port-level checker for the handle refcount table, bound to the top level.
// Depends on ghrt_pkg.
`timescale 1ns / 1ps

module ghrt_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [ghrt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [ghrt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    // a real operation keeps the input closed while it executes
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tdata[1:0] != ghrt_pkg::ACT_NONE)
        |=> !s_axis_tready)
        else $error("input taken while an operation executes");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

    // full and out-of-range words carry no id and no count
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && ((m_axis_tdata[2:0] == ghrt_pkg::ST_FULL)
                          || (m_axis_tdata[2:0] == ghrt_pkg::ST_RANGE))
        |-> (m_axis_tdata[60:13] == '0))
        else $error("rejected word carries id or count");

endmodule

bind generational_handle_refcount_table ghrt_chk u_ghrt_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
